>>> sv/dvad_pkg.sv
// shared constants, types and month-length function for the date stepper
package dvad_pkg;

  // field widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned STS_W   = 3;

  // calendar limits
  localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(3000);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

  // status codes
  localparam logic [STS_W-1:0] STS_OK        = STS_W'(0);
  localparam logic [STS_W-1:0] STS_BAD_YEAR  = STS_W'(1);
  localparam logic [STS_W-1:0] STS_BAD_MONTH = STS_W'(2);
  localparam logic [STS_W-1:0] STS_BAD_DAY   = STS_W'(3);
  localparam logic [STS_W-1:0] STS_OVERFLOW  = STS_W'(4);

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic check;
    logic step;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;
    logic fin;
  } dp_sts_t;

  // days in a month, julian leap rule
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    case (month) inside
      MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(30);
      MONTH_W'(2): len = (year[1:0] == 2'b00) ? DAY_W'(29) : DAY_W'(28);
      default:     len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

>>> sv/dvad_ctrl.sv
// controller state machine sequencing load, check, month steps and result
module dvad_ctrl import dvad_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    out_valid
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.bad ? S_OUT : S_STEP;
      end
      S_STEP: begin
        if (sts.fin) begin
          state_nxt = S_OUT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

>>> sv/dvad_dp.sv
// datapath: date registers, validity check and month-at-a-time stepping
module dvad_dp import dvad_pkg::*; (
  input  logic               clk,
  input  dp_cmd_t            cmd,
  input  logic [DAY_W-1:0]   in_day,
  input  logic [MONTH_W-1:0] in_month,
  input  logic [YEAR_W-1:0]  in_year,
  input  logic [DAYS_W-1:0]  in_days_to_add,
  output dp_sts_t            sts,
  output logic [DAY_W-1:0]   out_day,
  output logic [MONTH_W-1:0] out_month,
  output logic [YEAR_W-1:0]  out_year,
  output logic [STS_W-1:0]   out_status
);

  logic [DAY_W-1:0]   day_r,   day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r,  year_nxt;
  logic [DAYS_W-1:0]  rem_r,   rem_nxt;
  logic [STS_W-1:0]   stat_r,  stat_nxt;

  logic [DAY_W-1:0]   mlen;
  logic [DAY_W-1:0]   left;
  logic [STS_W-1:0]   chk_code;

  assign mlen = month_len(month_r, year_r);
  assign left = mlen - day_r;

  // start date check, year first, then month, then day
  always_comb begin
    if (year_r > MAX_YEAR) begin
      chk_code = STS_BAD_YEAR;
    end else if (month_r < MONTH_JAN || month_r > MONTH_DEC) begin
      chk_code = STS_BAD_MONTH;
    end else if (day_r < DAY_FIRST || day_r > mlen) begin
      chk_code = STS_BAD_DAY;
    end else begin
      chk_code = STS_OK;
    end
  end

  assign sts.bad = (chk_code != STS_OK);
  assign sts.fin = (rem_r == '0) || (stat_r != STS_OK);

  // next values of the working date
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rem_nxt   = rem_r;
    stat_nxt  = stat_r;
    if (cmd.load) begin
      day_nxt   = in_day;
      month_nxt = in_month;
      year_nxt  = in_year;
      rem_nxt   = in_days_to_add;
      stat_nxt  = STS_OK;
    end else if (cmd.check) begin
      // invalid start date gives a zero date
      if (chk_code != STS_OK) begin
        day_nxt   = '0;
        month_nxt = '0;
        year_nxt  = '0;
        stat_nxt  = chk_code;
      end
    end else if (cmd.step) begin
      if (rem_r <= {{(DAYS_W-DAY_W){1'b0}}, left}) begin
        // lands inside this month
        day_nxt = day_r + rem_r[DAY_W-1:0];
        rem_nxt = '0;
      end else begin
        // move to the first of the next month
        rem_nxt = rem_r - {{(DAYS_W-DAY_W){1'b0}}, left} - DAYS_W'(1);
        day_nxt = DAY_FIRST;
        if (month_r == MONTH_DEC) begin
          if (year_r == MAX_YEAR) begin
            // past the last supported year: saturate
            day_nxt   = DAY_LAST;
            month_nxt = MONTH_DEC;
            year_nxt  = MAX_YEAR;
            stat_nxt  = STS_OVERFLOW;
          end else begin
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + YEAR_W'(1);
          end
        end else begin
          month_nxt = month_r + MONTH_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    rem_r   <= rem_nxt;
    stat_r  <= stat_nxt;
  end

  assign out_day    = day_r;
  assign out_month  = month_r;
  assign out_year   = year_r;
  assign out_status = stat_r;

endmodule

>>> sv/date_validate_add_days.sv
// top level: date check and forward day stepping with status
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+-------------------
//   input    | in_day, in_month, in_year, in_days_to_add      | start && !busy
//   result   | out_day, out_month, out_year, out_status       | out_valid, 1 cycle
//
// one beat in, one beat out. an invalid date goes from the check state straight to
// the result strobe; a valid one first passes through the step state, one step per
// cycle, each step crossing into the next month or landing inside the current one.
// busy rises once a beat is accepted and stays high through the strobe cycle; the
// receiver cannot stall. rst_n is synchronous; reset returns the controller to idle.
module date_validate_add_days import dvad_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [DAY_W-1:0]   in_day,
  input  logic [MONTH_W-1:0] in_month,
  input  logic [YEAR_W-1:0]  in_year,
  input  logic [DAYS_W-1:0]  in_days_to_add,
  output logic               out_valid,
  output logic [DAY_W-1:0]   out_day,
  output logic [MONTH_W-1:0] out_month,
  output logic [YEAR_W-1:0]  out_year,
  output logic [STS_W-1:0]   out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  dvad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // date registers and step logic
  dvad_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .sts            (sts),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_status     (out_status)
  );

  // an accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // strobe only while busy, and only for one cycle
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a good result is a calendar date within range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_OK) |->
      (out_month >= MONTH_JAN && out_month <= MONTH_DEC &&
       out_year <= MAX_YEAR && out_day >= DAY_FIRST))
    else $error("ok result out of range");

  // a rejected start date comes with a zero date
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_BAD_YEAR || out_status == STS_BAD_MONTH ||
                   out_status == STS_BAD_DAY)) |->
      (out_day == '0 && out_month == '0 && out_year == '0))
    else $error("error result with non-zero date");

endmodule

>>> dv/date_add_checker.sv
// checker: predicts the stepped date for each accepted beat and compares results
`timescale 1ns / 1ps

module date_add_checker import dvad_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [DAY_W-1:0]   in_day,
  input  logic [MONTH_W-1:0] in_month,
  input  logic [YEAR_W-1:0]  in_year,
  input  logic [DAYS_W-1:0]  in_days_to_add,
  input  logic               out_valid,
  input  logic [DAY_W-1:0]   out_day,
  input  logic [MONTH_W-1:0] out_month,
  input  logic [YEAR_W-1:0]  out_year,
  input  logic [STS_W-1:0]   out_status,
  output int unsigned        mismatches,
  output int unsigned        outstanding,
  output int unsigned        n_checked,
  output int unsigned        n_advanced,
  output int unsigned        n_saturated,
  output int unsigned        n_rejected
);

  // short months, named by number
  localparam int unsigned MON_FEB = 2;
  localparam int unsigned MON_APR = 4;
  localparam int unsigned MON_JUN = 6;
  localparam int unsigned MON_SEP = 9;
  localparam int unsigned MON_NOV = 11;

  // calendar limits at integer width
  localparam int unsigned YEAR_TOP  = 32'(MAX_YEAR);
  localparam int unsigned MON_FIRST = 32'(MONTH_JAN);
  localparam int unsigned MON_LAST  = 32'(MONTH_DEC);
  localparam int unsigned DAY_LOW   = 32'(DAY_FIRST);

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [STS_W-1:0]   status;
  } date_beat_t;

  // dates still owed by the block, oldest first
  date_beat_t due_dates[$];

  // month length, leap year every fourth year
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: return (y % 4 == 0) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  // validate the start date, then walk forward a month at a time
  function automatic date_beat_t predict_date(input logic [DAY_W-1:0]   day_in,
                                              input logic [MONTH_W-1:0] month_in,
                                              input logic [YEAR_W-1:0]  year_in,
                                              input logic [DAYS_W-1:0]  count_in);
    date_beat_t  r;
    int unsigned d, m, y, rem, left;
    r   = '0;
    d   = 32'(day_in);
    m   = 32'(month_in);
    y   = 32'(year_in);
    rem = 32'(count_in);
    // year first, then month, then day; invalid dates give all-zero fields
    if (y > YEAR_TOP) begin
      r.status = STS_BAD_YEAR;
      return r;
    end
    if (m < MON_FIRST || m > MON_LAST) begin
      r.status = STS_BAD_MONTH;
      return r;
    end
    if (d < DAY_LOW || d > days_in_month(m, y)) begin
      r.status = STS_BAD_DAY;
      return r;
    end
    while (rem > 0) begin
      left = days_in_month(m, y) - d;
      if (rem <= left) begin
        d   = d + rem;
        rem = 0;
      end else begin
        rem = rem - (left + 1);
        d   = DAY_LOW;
        m   = m + 1;
        if (m > MON_LAST) begin
          m = MON_FIRST;
          y = y + 1;
          // past the last representable year: saturate on 31 december
          if (y > YEAR_TOP) begin
            r.day    = DAY_LAST;
            r.month  = MONTH_DEC;
            r.year   = MAX_YEAR;
            r.status = STS_OVERFLOW;
            return r;
          end
        end
      end
    end
    r.day    = DAY_W'(d);
    r.month  = MONTH_W'(m);
    r.year   = YEAR_W'(y);
    r.status = STS_OK;
    return r;
  endfunction

  // result beats first, then the input beat of the same edge
  always @(posedge clk) begin : watch
    date_beat_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (due_dates.size() == 0) begin
          $display("%0t: unexpected result, got day %0d month %0d year %0d status %0d",
                   $time, out_day, out_month, out_year, out_status);
          mismatches <= mismatches + 1;
        end else begin
          want = due_dates.pop_front();
          if (out_day !== want.day || out_month !== want.month ||
              out_year !== want.year || out_status !== want.status) begin
            $display("%0t: expected %0d-%0d-%0d st %0d, got %0d-%0d-%0d st %0d",
                     $time, want.day, want.month, want.year, want.status,
                     out_day, out_month, out_year, out_status);
            mismatches <= mismatches + 1;
          end
          n_checked <= n_checked + 1;
          if (want.status == STS_OK)
            n_advanced <= n_advanced + 1;
          else if (want.status == STS_OVERFLOW)
            n_saturated <= n_saturated + 1;
          else
            n_rejected <= n_rejected + 1;
        end
      end
      if (start && !busy)
        due_dates.push_back(predict_date(in_day, in_month, in_year, in_days_to_add));
      outstanding <= due_dates.size();
    end
  end

endmodule

>>> dv/date_validate_add_days_tb.sv
// testbench top: clock, reset, date stimulus and verdict for the date stepper
`timescale 1ns / 1ps

module date_validate_add_days_tb;
  import dvad_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_DATES   = 100;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic [DAY_W-1:0]   in_day         = '0;
  logic [MONTH_W-1:0] in_month       = '0;
  logic [YEAR_W-1:0]  in_year        = '0;
  logic [DAYS_W-1:0]  in_days_to_add = '0;
  logic               busy;
  logic               out_valid;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic [STS_W-1:0]   out_status;

  int unsigned mismatches, outstanding, n_checked, n_advanced, n_saturated, n_rejected;
  int unsigned burst_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  date_validate_add_days uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .out_valid      (out_valid),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_status     (out_status)
  );

  date_add_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .out_valid      (out_valid),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_status     (out_status),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .n_checked      (n_checked),
    .n_advanced     (n_advanced),
    .n_saturated    (n_saturated),
    .n_rejected     (n_rejected)
  );

  // present one beat and hold it until accepted, then maybe pause between bursts
  task automatic send_date(input logic [DAY_W-1:0]   d,
                           input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0]  y,
                           input logic [DAYS_W-1:0]  n);
    int unsigned gap;
    in_day         <= d;
    in_month       <= m;
    in_year        <= y;
    in_days_to_add <= n;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left = burst_left - 1;
    end
  endtask

  // mostly well-formed dates with random offsets, the rest raw noise
  task automatic send_random_date();
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [DAYS_W-1:0]  n;
    if ($urandom_range(0, 9) < 3) begin
      d = DAY_W'($urandom);
      m = MONTH_W'($urandom);
      y = YEAR_W'($urandom);
      n = DAYS_W'($urandom);
    end else begin
      m = MONTH_W'($urandom_range(32'(MONTH_JAN), 32'(MONTH_DEC)));
      if ($urandom_range(0, 3) == 0)
        d = DAY_W'($urandom_range(29, 31));
      else
        d = DAY_W'($urandom_range(1, 28));
      // years near the limit make overflow common
      if ($urandom_range(0, 3) == 0)
        y = YEAR_W'($urandom_range(2830, 32'(MAX_YEAR)));
      else
        y = YEAR_W'($urandom_range(0, 32'(MAX_YEAR)));
      case ($urandom_range(0, 3))
        0:       n = DAYS_W'($urandom_range(0, 62));
        1:       n = DAYS_W'($urandom_range(0, 1500));
        default: n = DAYS_W'($urandom);
      endcase
    end
    send_date(d, m, y, n);
  endtask

  // stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // range ends and overflow
    send_date(DAY_FIRST, MONTH_JAN, '0, '0);
    send_date(DAY_LAST, MONTH_DEC, MAX_YEAR, '0);
    send_date(DAY_LAST, MONTH_DEC, MAX_YEAR, DAYS_W'(1));
    send_date(DAY_FIRST, MONTH_JAN, MAX_YEAR - YEAR_W'(1), '1);
    send_date(DAY_FIRST, MONTH_JAN, '0, '1);
    send_date(DAY_W'(15), MONTH_W'(6), YEAR_W'(1234), DAYS_W'(16'h8000));
    // check order: every field bad reports the year, then the month
    send_date('0, '0, MAX_YEAR + YEAR_W'(1), DAYS_W'(5));
    send_date(DAY_LAST, MONTH_DEC, '1, '0);
    send_date('0, '0, YEAR_W'(2000), '0);
    send_date(DAY_FIRST, MONTH_W'(13), YEAR_W'(2000), DAYS_W'(1));
    send_date(DAY_FIRST, '1, YEAR_W'(2000), DAYS_W'(1));
    // day limits per month and leap rule
    send_date('0, MONTH_JAN, YEAR_W'(2000), DAYS_W'(1));
    send_date('1, MON_APR, YEAR_W'(2001), '0);
    send_date(DAY_W'(29), MON_FEB, YEAR_W'(2001), '0);
    send_date(DAY_W'(30), MON_FEB, YEAR_W'(2004), '0);
    send_date(DAY_W'(29), MON_FEB, YEAR_W'(2000), DAYS_W'(1));
    send_date(DAY_W'(28), MON_FEB, YEAR_W'(2001), DAYS_W'(1));
    send_date(DAY_W'(28), MON_FEB, YEAR_W'(2004), DAYS_W'(1));
    send_date(DAY_LAST, MONTH_JAN, YEAR_W'(2024), DAYS_W'(29));
    // month and year rollover
    send_date(DAY_W'(30), MON_APR, YEAR_W'(2023), DAYS_W'(1));
    send_date(DAY_LAST, MONTH_DEC, YEAR_W'(1999), DAYS_W'(1));
    send_date(DAY_FIRST, MONTH_JAN, YEAR_W'(1900), DAYS_W'(365));

    repeat (RANDOM_DATES) send_random_date();

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results checked: %0d dates advanced, %0d saturated at the year limit,",
             n_checked, n_advanced, n_saturated);
    $display("%0d start dates rejected, %0d mismatches", n_rejected, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
